[rtl/indexed_ordered_list_unit_assert.svh]
// Assertion macros shared by the checker of the indexed ordered list unit.
`ifndef INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("indexed_ordered_list_unit: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IOL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("indexed_ordered_list_unit: assertion failed");

`endif

[rtl/iol_pkg.sv]
// Shared types and constants for the indexed ordered list unit.
package iol_pkg;

    // Default number of entries the list can hold.
    localparam int CAPACITY_DEF = 64;

    // Field widths of the request and result transfers.
    localparam int REQ_W    = 2;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Padded stream widths.
    localparam int S_DATA_W = 40;  // position, value, pad
    localparam int M_DATA_W = 40;  // read_value, count, pad

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Source of the memory read address.
    typedef enum logic [2:0] {
        RA_LAST     = 3'd0,  // last held entry (count - 1)
        RA_NEXT_POS = 3'd1,  // entry after the request position
        RA_POS      = 3'd2,  // the request position
        RA_PTR_DN   = 3'd3,  // walk pointer minus one
        RA_PTR_UP   = 3'd4   // walk pointer plus one
    } ra_sel_t;

    // Target of the memory write.
    typedef enum logic [1:0] {
        WA_ABOVE = 2'd0,  // walk pointer plus one, data from the read port
        WA_BELOW = 2'd1,  // walk pointer minus one, data from the read port
        WA_POS   = 2'd2   // request position, data from the request
    } wa_sel_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        ra_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wr_sel;
        logic    cap_rd;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic ins_ok;
        logic rem_ok;
        logic rd_ok;
        logic ins_moves;
        logic rem_moves;
        logic ptr_above_pos;
        logic ptr_below_last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/iol_ram.sv]
// Generic simple dual-port RAM with a registered read port.
module iol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/iol_ctrl.sv]
// Controller state machine that sequences each list request.
module iol_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  iol_pkg::dp_stat_t stat,
    output iol_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_INS_MV  = 7'b0000100,
        S_INS_PUT = 7'b0001000,
        S_RM_MV   = 7'b0010000,
        S_RD_WAIT = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.load_req = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_sel   = iol_pkg::RA_POS;
        cmd.wr_en    = 1'b0;
        cmd.wr_sel   = iol_pkg::WA_POS;
        cmd.cap_rd   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.ins_ok) begin
                    if (stat.ins_moves) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = iol_pkg::RA_LAST;
                        state_next = S_INS_MV;
                    end else begin
                        state_next = S_INS_PUT;
                    end
                end else if (stat.rem_ok) begin
                    if (stat.rem_moves) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = iol_pkg::RA_NEXT_POS;
                        state_next = S_RM_MV;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (stat.rd_ok) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iol_pkg::RA_POS;
                    state_next = S_RD_WAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_INS_MV: begin
                // Entry read last cycle moves one place back.
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = iol_pkg::WA_ABOVE;
                if (stat.ptr_above_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iol_pkg::RA_PTR_DN;
                end else begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = iol_pkg::WA_POS;
                state_next = S_DONE;
            end
            S_RM_MV: begin
                // Entry read last cycle moves one place forward.
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = iol_pkg::WA_BELOW;
                if (stat.ptr_below_last) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iol_pkg::RA_PTR_UP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT: begin
                cmd.cap_rd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/iol_dp.sv]
// Datapath of the list: request registers, entry memory, count and result register.
module iol_dp #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [iol_pkg::REQ_W-1:0]     req_type,
    input  logic [iol_pkg::POS_W-1:0]     position,
    input  logic [iol_pkg::VAL_W-1:0]     value,
    input  iol_pkg::dp_cmd_t              cmd,
    output iol_pkg::dp_stat_t             stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [iol_pkg::STATUS_W-1:0]  status,
    output logic [iol_pkg::VAL_W-1:0]     read_value,
    output logic [iol_pkg::COUNT_W-1:0]   count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;

    logic [iol_pkg::REQ_W-1:0]    kind_reg;
    logic [iol_pkg::POS_W-1:0]    pos_reg;
    logic [iol_pkg::VAL_W-1:0]    val_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                ptr_reg;
    logic [CW-1:0]                ptr_next;
    logic [iol_pkg::VAL_W-1:0]    rdval_reg;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [iol_pkg::STATUS_W-1:0] status_reg;
    logic [iol_pkg::STATUS_W-1:0] status_next;
    logic [iol_pkg::VAL_W-1:0]    rdout_reg;
    logic [iol_pkg::COUNT_W-1:0]  cntout_reg;

    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic                      is_ins;
    logic                      is_rem;
    logic                      is_rd;
    logic                      pos_le_cnt;
    logic                      pos_lt_cnt;
    logic                      full;
    logic [CW-1:0]             rd_addr;
    logic [CW-1:0]             wr_addr;
    logic [iol_pkg::VAL_W-1:0] wr_data;
    logic [iol_pkg::VAL_W-1:0] ram_rd_data;

    assign pos_ext    = CMP_W'(pos_reg);
    assign cnt_ext    = CMP_W'(count_reg);
    assign is_ins     = (kind_reg == iol_pkg::REQ_INSERT);
    assign is_rem     = (kind_reg == iol_pkg::REQ_REMOVE);
    assign is_rd      = (kind_reg == iol_pkg::REQ_READ);
    assign pos_le_cnt = (pos_ext <= cnt_ext);
    assign pos_lt_cnt = (pos_ext < cnt_ext);
    assign full       = (count_reg == CW'(CAPACITY));

    assign stat.ins_ok         = is_ins && pos_le_cnt && !full;
    assign stat.rem_ok         = is_rem && pos_lt_cnt;
    assign stat.rd_ok          = is_rd && pos_lt_cnt;
    assign stat.ins_moves      = pos_lt_cnt;
    assign stat.rem_moves      = ((pos_ext + CMP_W'(1)) < cnt_ext);
    assign stat.ptr_above_pos  = (CMP_W'(ptr_reg) > pos_ext);
    assign stat.ptr_below_last = ((ptr_reg + CW'(1)) < count_reg);
    assign stat.out_free       = !m_tvalid_reg || m_tready;

    // Read address; the walk pointer follows every read.
    always_comb begin
        case (cmd.rd_sel)
            iol_pkg::RA_LAST:     rd_addr = count_reg - CW'(1);
            iol_pkg::RA_NEXT_POS: rd_addr = CW'(pos_reg) + CW'(1);
            iol_pkg::RA_POS:      rd_addr = CW'(pos_reg);
            iol_pkg::RA_PTR_DN:   rd_addr = ptr_reg - CW'(1);
            iol_pkg::RA_PTR_UP:   rd_addr = ptr_reg + CW'(1);
            default:              rd_addr = ptr_reg;
        endcase
    end

    always_comb begin
        case (cmd.wr_sel)
            iol_pkg::WA_ABOVE: begin
                wr_addr = ptr_reg + CW'(1);
                wr_data = ram_rd_data;
            end
            iol_pkg::WA_BELOW: begin
                wr_addr = ptr_reg - CW'(1);
                wr_data = ram_rd_data;
            end
            default: begin
                wr_addr = CW'(pos_reg);
                wr_data = val_reg;
            end
        endcase
    end

    assign ptr_next = cmd.rd_en ? rd_addr : ptr_reg;

    iol_ram #(
        .WIDTH (iol_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.load_out) begin
            if (stat.ins_ok) begin
                count_next = count_reg + CW'(1);
            end else if (stat.rem_ok) begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_comb begin
        if (is_ins) begin
            if (!pos_le_cnt) begin
                status_next = iol_pkg::ST_BAD_POS;
            end else if (full) begin
                status_next = iol_pkg::ST_FULL;
            end else begin
                status_next = iol_pkg::ST_OK;
            end
        end else if ((is_rem || is_rd) && pos_lt_cnt) begin
            status_next = iol_pkg::ST_OK;
        end else begin
            status_next = iol_pkg::ST_BAD_POS;
        end
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.load_req) begin
            kind_reg <= req_type;
            pos_reg  <= position;
            val_reg  <= value;
        end
        if (cmd.cap_rd) begin
            rdval_reg <= ram_rd_data;
        end
        if (cmd.load_out) begin
            status_reg <= status_next;
            rdout_reg  <= stat.rd_ok ? rdval_reg : '0;
            cntout_reg <= iol_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign status     = status_reg;
    assign read_value = rdout_reg;
    assign count      = cntout_reg;

endmodule

[rtl/indexed_ordered_list_unit.sv]
// Indexed ordered list: insert, remove and read by position in a RAM-backed sequence.
// Inserts and removes take longer the more entries lie after the position;
// reads and rejected requests move no entries.
// One request is in work at a time; entry moves go through the single RAM write port,
// one entry per cycle, and a new request is taken only once the last result is loaded.
// aresetn is synchronous, active low; it empties the list and drops any pending result.
module indexed_ordered_list_unit #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iol_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    input  logic [iol_pkg::S_DATA_W-1:0]  s_tdata,   // [6:0] position, [38:7] value, [39] zero
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [iol_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic [iol_pkg::M_DATA_W-1:0]  m_tdata    // [31:0] read_value, [38:32] count, [39] zero
);

    // The controller walks each request through decode, the entry moves and the
    // final result load. The datapath owns the entry RAM, the entry count, the
    // captured request and the result register, and reports the range checks
    // the controller branches on.
    //
    // An insert reads the last entry and, each cycle, writes the entry read in
    // the previous cycle one place back while reading the next one down, so
    // moves run at one entry per cycle. A remove walks upward the same way.
    // Read and write addresses in one cycle always differ.
    //
    // The count is updated in the same cycle the result is loaded, so every
    // decision before it sees the count from before the request. The result
    // register lets a new request transfer in while the previous result waits.

    iol_pkg::dp_cmd_t  cmd;
    iol_pkg::dp_stat_t stat;

    logic [iol_pkg::POS_W-1:0]    position;
    logic [iol_pkg::VAL_W-1:0]    value;
    logic [iol_pkg::STATUS_W-1:0] status;
    logic [iol_pkg::VAL_W-1:0]    read_value;
    logic [iol_pkg::COUNT_W-1:0]  count;

    // Unpack the request data fields, lowest field first.
    assign position = s_tdata[iol_pkg::POS_W-1:0];
    assign value    = s_tdata[iol_pkg::POS_W +: iol_pkg::VAL_W];

    iol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iol_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_type   (s_tuser),
        .position   (position),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    // Pack the result: read_value in the low bits, count above it, zero pad on top.
    assign m_tuser = status;
    assign m_tdata = {
        {(iol_pkg::M_DATA_W - iol_pkg::VAL_W - iol_pkg::COUNT_W){1'b0}},
        count,
        read_value
    };

endmodule

[rtl/iol_checker.sv]
// Port-level checker for the indexed ordered list unit and its bind.
`include "indexed_ordered_list_unit_assert.svh"

module iol_checker #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [iol_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    input logic [iol_pkg::S_DATA_W-1:0]  s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [iol_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    input logic [iol_pkg::M_DATA_W-1:0]  m_tdata    // [31:0] read_value, [38:32] count, [39] zero
);

    logic                        s_xfer;
    logic                        m_stall;
    logic                        m_err;
    logic                        m_full;
    logic [iol_pkg::VAL_W-1:0]   m_rdval;
    logic [iol_pkg::COUNT_W-1:0] m_count;

    assign s_xfer  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign m_rdval = m_tdata[iol_pkg::VAL_W-1:0];
    assign m_count = m_tdata[iol_pkg::VAL_W +: iol_pkg::COUNT_W];
    assign m_err   = m_tvalid && (m_tuser != iol_pkg::ST_OK);
    assign m_full  = m_tvalid && (m_tuser == iol_pkg::ST_FULL);

    // A stalled result holds its contents.
    `IOL_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // Requests are worked one at a time: no transfer in the cycle after one.
    `IOL_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_xfer, !s_tready)
    // Any result other than ok carries a zero read value.
    `IOL_ASSERT_SAME(a_err_zero, aclk, aresetn, m_err, m_rdval == '0)
    // A full report means the list holds exactly its capacity.
    `IOL_ASSERT_SAME(a_full_count, aclk, aresetn, m_full, m_count == iol_pkg::COUNT_W'(CAPACITY))

endmodule

bind indexed_ordered_list_unit iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker (.*);

[verif/tb_indexed_ordered_list_unit.sv]
// Self-checking testbench for the indexed ordered list unit: directed edge cases, random traffic.
module tb_indexed_ordered_list_unit;

    localparam int LIST_CAP       = iol_pkg::CAPACITY_DEF;
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    // The request kind that the block does not define; it must be rejected.
    localparam logic [iol_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        iol_pkg::status_t            status;
        logic [iol_pkg::VAL_W-1:0]   read_value;
        logic [iol_pkg::COUNT_W-1:0] count;
    } list_result_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [iol_pkg::REQ_W-1:0]    s_tuser  = '0;    // [1:0] req_type
    logic [iol_pkg::S_DATA_W-1:0] s_tdata  = '0;    // [6:0] position, [38:7] value, [39] zero
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [iol_pkg::STATUS_W-1:0] m_tuser;          // [1:0] status
    logic [iol_pkg::M_DATA_W-1:0] m_tdata;          // [31:0] read_value, [38:32] count, [39] zero

    // Shadow copy of the list, updated when a request transfer is accepted.
    logic [iol_pkg::VAL_W-1:0] list_vals [LIST_CAP];
    int                        list_len = 0;
    list_result_t              pending_results [$];
    list_result_t              oldest;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_off_req  = 1'b0;
    int   hold_left     = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    indexed_ordered_list_unit #(.CAPACITY(LIST_CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_indexed_ordered_list_unit: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transfer is compared with the oldest outstanding prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d value %h count %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[38:32]);
                mismatch_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_tuser !== oldest.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, oldest.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== oldest.read_value) begin
                    $display("%0t: read_value mismatch: expected %h actual %h",
                             $time, oldest.read_value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[38:32] !== oldest.count) begin
                    $display("%0t: count mismatch: expected %0d actual %0d",
                             $time, oldest.count, m_tdata[38:32]);
                    mismatch_count++;
                end
            end
        end
    end

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic list_result_t apply_list_request(
        input logic [iol_pkg::REQ_W-1:0] kind,
        input logic [iol_pkg::POS_W-1:0] pos,
        input logic [iol_pkg::VAL_W-1:0] val);
        list_result_t res;
        int           p;
        p              = int'(pos);
        res.status     = iol_pkg::ST_BAD_POS;
        res.read_value = '0;
        case (kind)
            iol_pkg::REQ_INSERT: begin
                if (p > list_len) begin
                    res.status = iol_pkg::ST_BAD_POS;
                end else if (list_len >= LIST_CAP) begin
                    res.status = iol_pkg::ST_FULL;
                end else begin
                    for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
                    list_vals[p] = val;
                    list_len++;
                    res.status = iol_pkg::ST_OK;
                end
            end
            iol_pkg::REQ_REMOVE: begin
                if (p < list_len) begin
                    for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                    res.status = iol_pkg::ST_OK;
                end
            end
            iol_pkg::REQ_READ: begin
                if (p < list_len) begin
                    res.read_value = list_vals[p];
                    res.status     = iol_pkg::ST_OK;
                end
            end
            default: res.status = iol_pkg::ST_BAD_POS;
        endcase
        res.count = iol_pkg::COUNT_W'(list_len);
        return res;
    endfunction

    // Offers one request, with random idle cycles first, and records its prediction
    // once the transfer is accepted. Valid stays high for a following request.
    task automatic send_request(input logic [iol_pkg::REQ_W-1:0] kind,
                                input logic [iol_pkg::POS_W-1:0] pos,
                                input logic [iol_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, val, pos};
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), apply_list_request(kind, pos, val));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Mostly a position that the current list makes legal, sometimes any position.
    function automatic logic [iol_pkg::POS_W-1:0] pick_position(
        input logic [iol_pkg::REQ_W-1:0] kind);
        int hi;
        if ($urandom_range(99) < 12) return iol_pkg::POS_W'($urandom_range(127));
        hi = (kind == iol_pkg::REQ_INSERT) ? list_len : list_len - 1;
        if (hi < 0) hi = 0;
        return iol_pkg::POS_W'($urandom_range(hi));
    endfunction

    task automatic test_empty_and_edges();
        send_request(iol_pkg::REQ_READ,   7'd0, 32'h0);
        send_request(iol_pkg::REQ_REMOVE, 7'd0, 32'h0);
        send_request(iol_pkg::REQ_INSERT, 7'd1, 32'h1234_5678);   // past the end of an empty list
        send_request(REQ_UNUSED, 7'd0, 32'hFFFF_FFFF);
        send_request(iol_pkg::REQ_INSERT, 7'd0, 32'h8000_0000);
        send_request(iol_pkg::REQ_INSERT, 7'd1, 32'h7FFF_FFFF);   // append
        send_request(iol_pkg::REQ_INSERT, 7'd0, 32'h0);           // new front
        send_request(iol_pkg::REQ_INSERT, 7'd1, 32'hFFFF_FFFF);   // middle
        send_request(iol_pkg::REQ_INSERT, 7'd127, 32'hA5A5_A5A5);
        for (int i = 0; i <= 4; i++) send_request(iol_pkg::REQ_READ, iol_pkg::POS_W'(i), 32'h0);
        send_request(iol_pkg::REQ_REMOVE, 7'd4, 32'h0);           // position equal to count
        send_request(iol_pkg::REQ_REMOVE, 7'd1, 32'h0);
        send_request(iol_pkg::REQ_REMOVE, 7'd0, 32'h0);
        send_request(iol_pkg::REQ_REMOVE, 7'd1, 32'h0);           // last entry
        send_request(iol_pkg::REQ_READ,   7'd0, 32'h0);
        send_request(REQ_UNUSED, 7'd127, 32'h0);
        send_request(iol_pkg::REQ_REMOVE, 7'd0, 32'h0);
        send_request(iol_pkg::REQ_READ,   7'd0, 32'h0);
    endtask

    // Fills the list to capacity, probes the full store, then refills it.
    task automatic test_fill_to_full();
        while (list_len < LIST_CAP)
            send_request(iol_pkg::REQ_INSERT, iol_pkg::POS_W'($urandom_range(list_len)),
                         $urandom());
        send_request(iol_pkg::REQ_INSERT, 7'd0, $urandom());
        send_request(iol_pkg::REQ_INSERT, iol_pkg::POS_W'(LIST_CAP), $urandom());
        send_request(iol_pkg::REQ_INSERT, iol_pkg::POS_W'($urandom_range(LIST_CAP)), $urandom());
        // A bad position is reported before fullness.
        send_request(iol_pkg::REQ_INSERT, iol_pkg::POS_W'(LIST_CAP + 1), $urandom());
        send_request(iol_pkg::REQ_INSERT, 7'd127, $urandom());
        send_request(iol_pkg::REQ_READ,   iol_pkg::POS_W'(LIST_CAP - 1), 32'h0);
        send_request(iol_pkg::REQ_READ,   iol_pkg::POS_W'(LIST_CAP), 32'h0);
        send_request(iol_pkg::REQ_REMOVE, iol_pkg::POS_W'(LIST_CAP - 1), 32'h0);
        send_request(iol_pkg::REQ_INSERT, iol_pkg::POS_W'(LIST_CAP - 1), $urandom());
        send_request(iol_pkg::REQ_INSERT, iol_pkg::POS_W'($urandom_range(LIST_CAP)), $urandom());
    endtask

    // Random requests; the insert and remove shares steer the list length.
    task automatic test_random_mix(input int n_items, input int ins_pct, input int rem_pct);
        int                        roll;
        logic [iol_pkg::REQ_W-1:0] kind;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 2)                          kind = REQ_UNUSED;
            else if (roll < 2 + ins_pct)           kind = iol_pkg::REQ_INSERT;
            else if (roll < 2 + ins_pct + rem_pct) kind = iol_pkg::REQ_REMOVE;
            else                                   kind = iol_pkg::REQ_READ;
            send_request(kind, pick_position(kind), $urandom());
        end
    endtask

    // The receiver holds off long enough for the block to stall its request side.
    task automatic test_output_backpressure();
        hold_off_req = 1'b1;
        test_random_mix(40, 40, 30);
    endtask

    // Short bursts, each followed by a pause until the block has answered all of it.
    task automatic test_quiet_bursts();
        for (int b = 0; b < 4; b++) begin
            test_random_mix(15, 35, 35);
            wait_all_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 29;
        recv_idle_pct = 62;
        test_empty_and_edges();
        test_fill_to_full();
        test_random_mix(330, 35, 30);

        send_idle_pct = 62;
        recv_idle_pct = 29;
        test_output_backpressure();
        test_random_mix(300, 55, 15);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_quiet_bursts();
        test_random_mix(150, 15, 55);
        test_random_mix(150, 35, 30);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_indexed_ordered_list_unit: PASS");
        else
            $display("tb_indexed_ordered_list_unit: FAIL");
        $finish;
    end

endmodule
